// ===== rtl/lcdim_pkg.sv =====
`default_nettype none

package lcdim_pkg;

  // Default crossfade length in refreshes (the fade itself runs one more).
  localparam int FADE_STEPS_DEF = 256;

  // Narrow operand of the shared multiply-divide unit, and the quotient width
  // that covers every product/divisor pair used by the sequencer.
  localparam int OPA_W = 8;
  localparam int Q_W   = 11;

  // Operation codes of the input item.
  localparam logic [1:0] OP_TICK       = 2'd0;
  localparam logic [1:0] OP_SET_TEMP   = 2'd1;
  localparam logic [1:0] OP_SET_BRIGHT = 2'd2;

  // Color and brightness constants.
  localparam logic [7:0] LEVEL_FULL    = 8'hFF;
  localparam logic [7:0] WHITE_BASE    = 8'd50;
  localparam logic [7:0] TEMP_SPAN_MUL = 8'd205;
  localparam logic [7:0] DIV_BY_255    = 8'd255;
  localparam logic [7:0] RAMP_DIV      = 8'd128;
  localparam logic [7:0] RAMP_FULL     = 8'd128;
  localparam logic [7:0] RAMP_INC      = 8'd4;
  localparam int         KELVIN_MUL    = 2000;
  localparam int         KELVIN_W      = $clog2(KELVIN_MUL + 1);
  localparam logic [12:0] KELVIN_BASE  = 13'd3000;

  // Reset values: target color for setting 128, and its color temperature.
  localparam int          RST_SETTING = 128;
  localparam int          RST_SPAN    = RST_SETTING * 205 / 255;
  localparam logic [7:0]  RST_WHITE   = 8'(50 + RST_SPAN);
  localparam logic [7:0]  RST_YELLOW  = 8'(255 - RST_SPAN);
  localparam logic [12:0] RST_KELVIN  = 13'(3000 + RST_SETTING * 2000 / 255);

  // Refresh timer intervals in ms.
  localparam logic [6:0] RST_INTERVAL  = 7'd100;
  localparam logic [6:0] FADE_INTERVAL = 7'd2;
  localparam logic [6:0] IDLE_INTERVAL = 7'd1;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] value;
  } lcdim_in_t;

  typedef struct packed {
    logic [7:0]  night_duty;
    logic [7:0]  white_duty;
    logic [7:0]  yellow_duty;
    logic        fading;
    logic        ramping;
    logic [7:0]  target_brightness;
    logic [12:0] color_temp_kelvin;
  } lcdim_out_t;

  // Status of the multiply-divide unit as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
    logic rem_nz;
  } lcdim_md_stat_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } lcdim_md_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAMP,
    ST_TIMER,
    ST_FADE,
    ST_DUTY,
    ST_TEMP,
    ST_KELVIN,
    ST_DONE
  } lcdim_state_t;

endpackage

`default_nettype wire

// ===== rtl/lcdim_muldiv.sv =====
`default_nettype none

// Bit-serial floor(opa * opb / divisor): shift-add multiply one multiplier
// bit per cycle, then restoring division one quotient bit per cycle.
module lcdim_muldiv #(
  parameter int MUL_W = 11,
  parameter int DIV_W = 9
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [lcdim_pkg::OPA_W-1:0]   opa,
  input  wire logic [MUL_W-1:0]              opb,
  input  wire logic [DIV_W-1:0]              divisor,
  output logic      [lcdim_pkg::Q_W-1:0]     quot,
  output lcdim_pkg::lcdim_md_stat_t          stat
);
  import lcdim_pkg::*;

  localparam int PROD_W = OPA_W + MUL_W;
  localparam int CNT_W  = $clog2(PROD_W + 1);

  lcdim_md_state_t   md_state_r, md_state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [OPA_W-1:0]  a_r, a_nxt;
  logic [MUL_W-1:0]  b_r, b_nxt;
  logic [DIV_W-1:0]  d_r, d_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic              done_r, done_nxt;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              ge;

  assign trial = {rem_r, acc_r[PROD_W-1]};
  assign diff  = trial - {1'b0, d_r};
  assign ge    = (trial >= {1'b0, d_r});

  always_comb begin
    md_state_nxt = md_state_r;
    case (md_state_r)
      MD_IDLE: begin
        if (start) begin
          md_state_nxt = MD_MUL;
        end
      end
      MD_MUL: begin
        if (cnt_r == CNT_W'(1)) begin
          md_state_nxt = MD_DIV;
        end
      end
      MD_DIV: begin
        if (cnt_r == CNT_W'(1)) begin
          md_state_nxt = MD_IDLE;
        end
      end
      default: md_state_nxt = MD_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    case (md_state_r)
      MD_IDLE: begin
        if (start) begin
          a_nxt   = opa;
          b_nxt   = opb;
          d_nxt   = divisor;
          acc_nxt = '0;
          rem_nxt = '0;
          cnt_nxt = CNT_W'(MUL_W);
        end
      end
      MD_MUL: begin
        acc_nxt = {acc_r[PROD_W-2:0], 1'b0} + (b_r[MUL_W-1] ? PROD_W'(a_r) : '0);
        b_nxt   = {b_r[MUL_W-2:0], 1'b0};
        cnt_nxt = (cnt_r == CNT_W'(1)) ? CNT_W'(PROD_W) : cnt_r - 1'b1;
      end
      MD_DIV: begin
        // dividend bits leave at the top, quotient bits enter at the bottom
        rem_nxt  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        acc_nxt  = {acc_r[PROD_W-2:0], ge};
        cnt_nxt  = cnt_r - 1'b1;
        done_nxt = (cnt_r == CNT_W'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_state_r <= MD_IDLE;
      cnt_r      <= '0;
      done_r     <= 1'b0;
    end else begin
      md_state_r <= md_state_nxt;
      cnt_r      <= cnt_nxt;
      done_r     <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

  assign quot        = acc_r[Q_W-1:0];
  assign stat.busy   = (md_state_r != MD_IDLE);
  assign stat.done   = done_r;
  assign stat.rem_nz = |rem_r;

endmodule

`default_nettype wire

// ===== rtl/lamp_crossfade_dimmer_top.sv =====
// Work: a tick runs 3 to 7 products on the shared multiply-divide unit, a temperature
//   set 2 products, a brightness set or no-op none.
// Throughput: one item at a time; the serial multiply-divide unit sets the rate.
// The result register lets the next item in while a result still waits.
// Reset (rst_n low, synchronous): levels dark, fade toward setting 128 armed.
`default_nettype none

module lamp_crossfade_dimmer_top #(
  parameter int FADE_STEPS = lcdim_pkg::FADE_STEPS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire lcdim_pkg::lcdim_in_t in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output lcdim_pkg::lcdim_out_t     out_data
);
  import lcdim_pkg::*;

  // fade step counter holds 0..FADE_STEPS; unit widths cover every operand
  localparam int FS_W  = $clog2(FADE_STEPS + 1);
  localparam int MUL_W = (FS_W > KELVIN_W) ? FS_W : KELVIN_W;
  localparam int DIV_W = (FS_W > 8) ? FS_W : 8;

  lcdim_state_t state_r, state_nxt;
  logic [1:0]   ch_r;        // channel being worked: 0 night, 1 white, 2 yellow
  logic         pend_r;      // product in flight on the unit
  logic [7:0]   value_r;

  logic [7:0]   level_r [3];
  logic [7:0]   fstart_r [3];
  logic [7:0]   ftgt_r [3];
  logic [FS_W-1:0] fade_step_r;
  logic         fade_active_r;
  logic [6:0]   elapsed_r;
  logic [6:0]   interval_r;
  logic [7:0]   ramp_start_r;
  logic [7:0]   ramp_tgt_r;
  logic [7:0]   ramp_step_r;
  logic         ramp_active_r;
  logic [7:0]   bright_r;
  logic [7:0]   duty_r [3];
  logic [12:0]  kelvin_r;
  logic         out_valid_r;
  lcdim_out_t   out_data_r;

  logic         in_acc;
  logic         out_load;

  // multiply-divide unit hookup
  logic              md_start;
  logic [OPA_W-1:0]  md_a;
  logic [MUL_W-1:0]  md_b;
  logic [DIV_W-1:0]  md_d;
  logic [Q_W-1:0]    md_quot;
  lcdim_md_stat_t    md_stat;

  // ramp helpers
  logic       r_neg;
  logic [7:0] r_mag;
  logic [7:0] r_stp;
  logic [7:0] r_level;
  logic [8:0] r_step_inc;

  // fade helpers
  logic [7:0] f_a;
  logic [7:0] f_b;
  logic       f_neg;
  logic [7:0] f_mag;
  logic [7:0] f_level;

  // refresh timer
  logic [7:0] elap_inc;
  logic [6:0] limit;
  logic       refresh;

  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign r_neg      = (ramp_tgt_r < ramp_start_r);
  assign r_mag      = r_neg ? (ramp_start_r - ramp_tgt_r) : (ramp_tgt_r - ramp_start_r);
  assign r_stp      = (ramp_step_r > RAMP_FULL) ? RAMP_FULL : ramp_step_r;
  // negative steps round toward minus infinity: add one if anything was left over
  assign r_level    = r_neg ? (ramp_start_r - md_quot[7:0] - {7'd0, md_stat.rem_nz})
                            : (ramp_start_r + md_quot[7:0]);
  assign r_step_inc = {1'b0, ramp_step_r} + {1'b0, RAMP_INC};

  assign f_a     = fstart_r[ch_r];
  assign f_b     = ftgt_r[ch_r];
  assign f_neg   = (f_b < f_a);
  assign f_mag   = f_neg ? (f_a - f_b) : (f_b - f_a);
  // fade quotient truncates toward zero, so the sign goes on after the divide
  assign f_level = f_neg ? (f_a - md_quot[7:0]) : (f_a + md_quot[7:0]);

  assign elap_inc = {1'b0, elapsed_r} + 8'd1;
  assign limit    = (interval_r == 7'd0) ? IDLE_INTERVAL : interval_r;
  assign refresh  = (elap_inc >= {1'b0, limit});

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.operation)
            OP_TICK:     state_nxt = ramp_active_r ? ST_RAMP : ST_TIMER;
            OP_SET_TEMP: state_nxt = ST_TEMP;
            default:     state_nxt = ST_DONE;
          endcase
        end
      end
      ST_RAMP: begin
        if (md_stat.done) begin
          state_nxt = ST_TIMER;
        end
      end
      ST_TIMER: begin
        state_nxt = (refresh && fade_active_r) ? ST_FADE : ST_DUTY;
      end
      ST_FADE: begin
        if (md_stat.done && ch_r == 2'd2) begin
          state_nxt = ST_DUTY;
        end
      end
      ST_DUTY: begin
        if (md_stat.done && ch_r == 2'd2) begin
          state_nxt = ST_DONE;
        end
      end
      ST_TEMP: begin
        if (md_stat.done) begin
          state_nxt = ST_KELVIN;
        end
      end
      ST_KELVIN: begin
        if (md_stat.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: unit launch and operand select
  always_comb begin
    md_start = 1'b0;
    md_a     = '0;
    md_b     = '0;
    md_d     = DIV_W'(DIV_BY_255);
    in_stall = (state_r != ST_IDLE);
    case (state_r)
      ST_RAMP: begin
        md_start = !pend_r;
        md_a     = r_mag;
        md_b     = MUL_W'(r_stp);
        md_d     = DIV_W'(RAMP_DIV);
      end
      ST_FADE: begin
        md_start = !pend_r;
        md_a     = f_mag;
        md_b     = MUL_W'(fade_step_r);
        md_d     = DIV_W'(FADE_STEPS);
      end
      ST_DUTY: begin
        md_start = !pend_r;
        md_a     = level_r[ch_r];
        md_b     = MUL_W'(bright_r);
      end
      ST_TEMP: begin
        md_start = !pend_r;
        md_a     = value_r;
        md_b     = MUL_W'(TEMP_SPAN_MUL);
      end
      ST_KELVIN: begin
        md_start = !pend_r;
        md_a     = value_r;
        md_b     = MUL_W'(KELVIN_MUL);
      end
      default: ;
    endcase
  end

  lcdim_muldiv #(
    .MUL_W (MUL_W),
    .DIV_W (DIV_W)
  ) u_muldiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (md_start),
    .opa     (md_a),
    .opb     (md_b),
    .divisor (md_d),
    .quot    (md_quot),
    .stat    (md_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      ch_r          <= 2'd0;
      pend_r        <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        level_r[k]  <= 8'd0;
        fstart_r[k] <= 8'd0;
        duty_r[k]   <= 8'd0;
      end
      ftgt_r[0]     <= LEVEL_FULL;
      ftgt_r[1]     <= RST_WHITE;
      ftgt_r[2]     <= RST_YELLOW;
      fade_step_r   <= '0;
      fade_active_r <= 1'b1;
      elapsed_r     <= 7'd0;
      interval_r    <= RST_INTERVAL;
      ramp_start_r  <= 8'd0;
      ramp_tgt_r    <= 8'd0;
      ramp_step_r   <= 8'd0;
      ramp_active_r <= 1'b1;
      bright_r      <= 8'd0;
      kelvin_r      <= RST_KELVIN;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (md_start) begin
        pend_r <= 1'b1;
      end else if (md_stat.done) begin
        pend_r <= 1'b0;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc && in_data.operation == OP_SET_BRIGHT) begin
            ramp_start_r  <= ramp_tgt_r;
            ramp_tgt_r    <= in_data.value;
            ramp_active_r <= 1'b1;
            ramp_step_r   <= 8'd0;
          end
        end
        ST_RAMP: begin
          if (md_stat.done) begin
            bright_r    <= r_level;
            ramp_step_r <= r_step_inc[7:0];
            if (r_step_inc > {1'b0, RAMP_FULL}) begin
              ramp_active_r <= 1'b0;
            end
          end
        end
        ST_TIMER: begin
          if (refresh) begin
            elapsed_r <= 7'd0;
            if (fade_active_r) begin
              interval_r <= FADE_INTERVAL;
            end else begin
              interval_r <= IDLE_INTERVAL;
              for (int k = 0; k < 3; k++) begin
                level_r[k] <= ftgt_r[k];
              end
            end
          end else begin
            elapsed_r <= elap_inc[6:0];
          end
        end
        ST_FADE: begin
          if (md_stat.done) begin
            level_r[ch_r] <= f_level;
            if (ch_r == 2'd2) begin
              ch_r <= 2'd0;
              // last step holds the count at the end and closes the fade
              if (fade_step_r >= FS_W'(FADE_STEPS)) begin
                fade_active_r <= 1'b0;
              end else begin
                fade_step_r <= fade_step_r + 1'b1;
              end
            end else begin
              ch_r <= ch_r + 2'd1;
            end
          end
        end
        ST_DUTY: begin
          if (md_stat.done) begin
            duty_r[ch_r] <= md_quot[7:0];
            ch_r         <= (ch_r == 2'd2) ? 2'd0 : ch_r + 2'd1;
          end
        end
        ST_TEMP: begin
          if (md_stat.done) begin
            ftgt_r[0]     <= LEVEL_FULL;
            ftgt_r[1]     <= WHITE_BASE + md_quot[7:0];
            ftgt_r[2]     <= LEVEL_FULL - md_quot[7:0];
            for (int k = 0; k < 3; k++) begin
              fstart_r[k] <= level_r[k];
            end
            fade_active_r <= 1'b1;
            fade_step_r   <= '0;
          end
        end
        ST_KELVIN: begin
          if (md_stat.done) begin
            kelvin_r <= KELVIN_BASE + 13'(md_quot);
          end
        end
        default: ;
      endcase
    end
  end

  // value is only needed for the temperature products
  always_ff @(posedge clk) begin
    if (in_acc) begin
      value_r <= in_data.value;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.night_duty        <= duty_r[0];
      out_data_r.white_duty        <= duty_r[1];
      out_data_r.yellow_duty       <= duty_r[2];
      out_data_r.fading            <= fade_active_r;
      out_data_r.ramping           <= ramp_active_r;
      out_data_r.target_brightness <= ramp_tgt_r;
      out_data_r.color_temp_kelvin <= kelvin_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_fade_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fade_step_r <= FS_W'(FADE_STEPS))
    else $error("fade step past end of crossfade");

  a_ramp_end: assert property (@(posedge clk) disable iff (!rst_n)
    !ramp_active_r |-> ramp_step_r > RAMP_FULL)
    else $error("ramp closed before full step");

  a_done_pending: assert property (@(posedge clk) disable iff (!rst_n)
    md_stat.done |-> pend_r)
    else $error("unit result with no product in flight");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    md_start |-> !md_stat.busy)
    else $error("product launched on busy unit");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result shown outside the publish step");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import lcdim_pkg::*;

  // Fade length used for both the block and the local predictor.
  localparam int FADE_LEN = FADE_STEPS_DEF;

  // Operation code 3 has no function; the block must still answer it.
  localparam logic [1:0] OP_NONE = 2'd3;

  // Receiver hold-off used to fill the block and force input stalls.
  localparam int HOLD_OFF_CYCLES = 600;

  // Allow a wide margin after the last result.
  localparam int SETTLE_CYCLES = 400;
  localparam int DRAIN_LIMIT   = 100000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  lcdim_in_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  lcdim_out_t out_data;

  lamp_crossfade_dimmer_top #(
    .FADE_STEPS(FADE_LEN)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Lamp predictor state
  // ---------------------------------------------------------------------------
  logic [7:0]  lvl [3];        // night, white, yellow
  logic [23:0] fade_from;
  logic [23:0] fade_to;
  int          fade_idx;
  bit          fade_on;
  int          refresh_count;
  int          refresh_period;
  logic [7:0]  bright_from;
  logic [7:0]  bright_to;
  int          ramp_idx;
  bit          ramp_on;
  logic [7:0]  bright_now;
  logic [7:0]  temp_sel;

  lcdim_out_t  lamp_pending [$];   // predicted results, oldest first
  int          fail_count = 0;

  // Sender burst bookkeeping
  int burst_left = 0;

  // Receiver hold-off handshake: test side bumps asks, receiver tracks served.
  int hold_off_asks = 0;
  int hold_off_served = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int stall_phase_left = 0;

  // Target color packed as night<<16 | white<<8 | yellow.
  function automatic logic [23:0] temp_color(logic [7:0] t);
    int span;
    span = int'(t) * 205 / 255;
    return {8'hFF, 8'(50 + span), 8'(255 - span)};
  endfunction

  function automatic void lamp_reset_model();
    foreach (lvl[k]) lvl[k] = 8'd0;
    fade_from      = 24'd0;
    fade_to        = temp_color(8'(RST_SETTING));
    fade_idx       = 0;
    fade_on        = 1'b1;
    refresh_count  = 0;
    refresh_period = 100;
    bright_from    = 8'd0;
    bright_to      = 8'd0;
    ramp_idx       = 0;
    ramp_on        = 1'b1;
    bright_now     = 8'd0;
    temp_sel       = 8'(RST_SETTING);
  endfunction

  // Advances the predictor by one accepted item and returns the lamp result.
  function automatic lcdim_out_t lamp_predict(lcdim_in_t item);
    lcdim_out_t res;
    int         period;
    int         s;
    int         prod;
    int         level;
    int         lum;
    int         a;
    int         b;
    int         v;
    case (item.operation)
      OP_TICK: begin
        // brightness ramp first, floor scaling on both signs
        if (ramp_on) begin
          s = (ramp_idx > 128) ? 128 : ramp_idx;
          prod = (int'(bright_to) - int'(bright_from)) * s;
          if (prod >= 0) begin
            level = int'(bright_from) + prod / 128;
          end else begin
            level = int'(bright_from) - (-prod + 127) / 128;
          end
          bright_now = level[7:0];
          ramp_idx += 4;
          if (ramp_idx > 128) ramp_on = 1'b0;
        end
        // refresh timer; a zero period counts as one
        refresh_count++;
        period = (refresh_period < 1) ? 1 : refresh_period;
        if (refresh_count >= period) begin
          refresh_count = 0;
          if (fade_on) begin
            lum = (fade_idx > FADE_LEN) ? FADE_LEN : fade_idx;
            for (int k = 0; k < 3; k++) begin
              a = int'(fade_from[16 - 8 * k +: 8]);
              b = int'(fade_to[16 - 8 * k +: 8]);
              v = a + ((b - a) * lum) / FADE_LEN;   // truncates toward zero
              lvl[k] = v[7:0];
            end
            fade_idx++;
            if (fade_idx > FADE_LEN) begin
              fade_on = 1'b0;
              fade_idx = FADE_LEN;
            end
            refresh_period = 2;
          end else begin
            lvl[0] = fade_to[23:16];
            lvl[1] = fade_to[15:8];
            lvl[2] = fade_to[7:0];
            refresh_period = 1;
          end
        end
      end
      OP_SET_TEMP: begin
        temp_sel  = item.value;
        fade_from = {lvl[0], lvl[1], lvl[2]};
        fade_to   = temp_color(item.value);
        fade_on   = 1'b1;
        fade_idx  = 0;
      end
      OP_SET_BRIGHT: begin
        bright_from = bright_to;
        bright_to   = item.value;
        ramp_on     = 1'b1;
        ramp_idx    = 0;
      end
      default: ;
    endcase
    res.night_duty        = 8'(int'(lvl[0]) * int'(bright_now) / 255);
    res.white_duty        = 8'(int'(lvl[1]) * int'(bright_now) / 255);
    res.yellow_duty       = 8'(int'(lvl[2]) * int'(bright_now) / 255);
    res.fading            = fade_on;
    res.ramping           = ramp_on;
    res.target_brightness = bright_to;
    res.color_temp_kelvin = 13'(3000 + int'(temp_sel) * 2000 / 255);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one item per call, bursts of random length with random gaps.
  // Must be called right after a rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] op, input logic [7:0] val);
    lcdim_in_t item;
    item.operation = op;
    item.value     = val;
    in_data  <= item;
    in_valid <= 1'b1;
    // pre-edge stall is what the block saw at this edge
    do @(posedge clk); while (in_stall);
    lamp_pending.push_back(lamp_predict(item));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // mostly short bursts, now and then a long unbroken run
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 5);
    end
  endtask

  // Biased toward the field extremes.
  function automatic logic [7:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern in phases (none, light, heavy), plus long hold-off
  // on request from a test.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_off_asks != hold_off_served) begin
      hold_off_served = hold_off_asks;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (stall_phase_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_phase_left = $urandom_range(10, 80);
    end else begin
      stall_phase_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    lcdim_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (lamp_pending.size() == 0) begin
        fail_count++;
        $display("%0t: result with nothing pending, got %h", $time, out_data);
      end else begin
        want = lamp_pending.pop_front();
        check_field("night_duty", want.night_duty, out_data.night_duty);
        check_field("white_duty", want.white_duty, out_data.white_duty);
        check_field("yellow_duty", want.yellow_duty, out_data.yellow_duty);
        check_field("fading", want.fading, out_data.fading);
        check_field("ramping", want.ramping, out_data.ramping);
        check_field("target_brightness", want.target_brightness,
                    out_data.target_brightness);
        check_field("color_temp_kelvin", want.color_temp_kelvin,
                    out_data.color_temp_kelvin);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset state: fade armed toward setting 128, ramp armed, levels dark.
  // Includes the unused op code, which must return the current result.
  task automatic test_reset_outputs();
    send_item(OP_NONE, 8'hFF);
    send_item(OP_TICK, 8'h00);
  endtask

  // Field extremes, every op, falling ramp (negative floor), alternating bits.
  task automatic test_directed_extremes();
    send_item(OP_SET_BRIGHT, 8'hFF);
    repeat (3) send_item(OP_TICK, 8'hFF);
    send_item(OP_SET_TEMP, 8'h00);
    repeat (2) send_item(OP_TICK, 8'h55);
    send_item(OP_SET_TEMP, 8'hFF);
    send_item(OP_SET_BRIGHT, 8'h00);
    repeat (3) send_item(OP_TICK, 8'hAA);
    send_item(OP_NONE, 8'h00);
    send_item(OP_SET_BRIGHT, 8'h55);
    send_item(OP_SET_TEMP, 8'hAA);
    send_item(OP_TICK, 8'h00);
    send_item(OP_SET_BRIGHT, 8'hAA);
    send_item(OP_TICK, 8'h00);
    send_item(OP_SET_TEMP, 8'h55);
    send_item(OP_TICK, 8'hFF);
  endtask

  // One temperature set, then enough ticks to cover the 100 ms first refresh,
  // the full crossfade at 2 ms and the 1 ms idle refreshes after it.
  // Brightness sets and dead ops are mixed in; no temperature set restarts it.
  task automatic test_fade_to_completion();
    int r;
    send_item(OP_SET_TEMP, pick_value());
    send_item(OP_SET_BRIGHT, pick_value());
    for (int i = 0; i < 680; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) send_item(OP_SET_BRIGHT, pick_value());
      else if (r < 5) send_item(OP_NONE, 8'($urandom_range(0, 255)));
      else send_item(OP_TICK, 8'($urandom_range(0, 255)));
    end
  endtask

  // Receiver holds off while the sender keeps offering mostly fast items,
  // so the result register and the working item fill and the input stalls.
  task automatic test_backpressure();
    int r;
    hold_off_asks++;
    for (int i = 0; i < 24; i++) begin
      r = $urandom_range(0, 9);
      if (r < 5) send_item(OP_SET_BRIGHT, pick_value());
      else if (r < 8) send_item(OP_NONE, 8'($urandom_range(0, 255)));
      else send_item(OP_TICK, 8'($urandom_range(0, 255)));
    end
  endtask

  // Mixed traffic: mostly ticks, with sets landing mid-fade and mid-ramp.
  task automatic test_random_mix();
    int r;
    for (int i = 0; i < 130; i++) begin
      r = $urandom_range(0, 99);
      if (r < 65) send_item(OP_TICK, 8'($urandom_range(0, 255)));
      else if (r < 82) send_item(OP_SET_BRIGHT, pick_value());
      else if (r < 92) send_item(OP_SET_TEMP, pick_value());
      else send_item(OP_NONE, 8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int waited;
    waited = 0;
    lamp_reset_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_outputs();
    test_directed_extremes();
    test_fade_to_completion();
    test_backpressure();
    test_random_mix();
    in_valid <= 1'b0;

    // drain, then give any stray result time to show up
    while (lamp_pending.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && lamp_pending.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog: well above the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lcdim_pkg.sv
rtl/lcdim_muldiv.sv
rtl/lamp_crossfade_dimmer_top.sv
test/tb_top.sv
